// File: rtl/mts_pkg.sv
// mts_pkg: shared constants, codes and control types of the min tracking stack
// no dependencies; imported by every module of the block except mts_ram
`default_nettype none

package mts_pkg;

  localparam int STACK_DEPTH = 256;
  localparam int ADDR_W      = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
  localparam int DATA_W      = 32;

  localparam logic CMD_PUSH = 1'b0;
  localparam logic CMD_POP  = 1'b1;

  typedef enum logic [1:0] {
    ST_DONE      = 2'd0,
    ST_POP_EMPTY = 2'd1,
    ST_PUSH_FULL = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_LOAD,
    S_DONE
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic accept;
    logic load;
  } dp_ctrl_t;

  // datapath to controller
  typedef struct packed {
    logic needs_load;
  } dp_stat_t;

endpackage

`default_nettype wire

// File: rtl/mts_ram.sv
// mts_ram: generic single write port ram with registered read
// no dependencies; holds the value and minimum stores
`default_nettype none

module mts_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  wire logic                                   clk,
  input  wire logic                                   we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                       wdata,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// File: rtl/mts_datapath.sv
// mts_datapath: counts, cached tops, the two stores and the result registers
// depends on mts_pkg and mts_ram
`default_nettype none

module mts_datapath
  import mts_pkg::*;
(
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire dp_ctrl_t                 ctrl,
  input  wire logic                     command,
  input  wire logic signed [DATA_W-1:0] value,
  output dp_stat_t                      stat,
  output logic [1:0]                    status,
  output logic                          is_empty,
  output logic [CNT_W-1:0]              fill_count,
  output logic signed [DATA_W-1:0]      top_value,
  output logic signed [DATA_W-1:0]      min_value
);

  logic [CNT_W-1:0]         vcount;
  logic [CNT_W-1:0]         mcount;
  logic signed [DATA_W-1:0] vtop;
  logic signed [DATA_W-1:0] mtop;
  status_t                  status_r;

  logic                     is_full;
  logic                     do_push;
  logic                     do_pop;
  logic                     min_push;
  logic                     min_pop;
  logic [CNT_W-1:0]         vcount_next;
  logic [CNT_W-1:0]         mcount_next;
  logic [CNT_W-1:0]         vrd_cnt;
  logic [CNT_W-1:0]         mrd_cnt;
  logic [DATA_W-1:0]        vrd_data;
  logic [DATA_W-1:0]        mrd_data;

  assign is_full  = (vcount == CNT_W'(STACK_DEPTH));
  assign do_push  = (command == CMD_PUSH) && !is_full;
  assign do_pop   = (command == CMD_POP) && (vcount != '0);
  // mcount never exceeds vcount, so a push that fits also fits the min store
  assign min_push = do_push && ((mcount == '0) || (value <= mtop));
  assign min_pop  = do_pop && (mcount != '0) && (mtop == vtop);

  assign stat.needs_load = do_pop;

  always_comb begin
    vcount_next = vcount;
    mcount_next = mcount;
    if (do_push) begin
      vcount_next = vcount + CNT_W'(1);
    end else if (do_pop) begin
      vcount_next = vcount - CNT_W'(1);
    end
    if (min_push) begin
      mcount_next = mcount + CNT_W'(1);
    end else if (min_pop) begin
      mcount_next = mcount - CNT_W'(1);
    end
  end

  // read addresses of the new tops after a pop
  assign vrd_cnt = vcount_next - CNT_W'(1);
  assign mrd_cnt = mcount_next - CNT_W'(1);

  mts_ram #(.WIDTH(DATA_W), .DEPTH(STACK_DEPTH)) u_vram (
    .clk   (clk),
    .we    (ctrl.accept && do_push),
    .waddr (vcount[ADDR_W-1:0]),
    .wdata (value),
    .raddr (vrd_cnt[ADDR_W-1:0]),
    .rdata (vrd_data)
  );

  mts_ram #(.WIDTH(DATA_W), .DEPTH(STACK_DEPTH)) u_mram (
    .clk   (clk),
    .we    (ctrl.accept && min_push),
    .waddr (mcount[ADDR_W-1:0]),
    .wdata (value),
    .raddr (mrd_cnt[ADDR_W-1:0]),
    .rdata (mrd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      vcount <= '0;
      mcount <= '0;
    end else if (ctrl.accept) begin
      vcount <= vcount_next;
      mcount <= mcount_next;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.accept) begin
      if (do_push) begin
        vtop <= value;
      end
      if (min_push) begin
        mtop <= value;
      end
      if ((command == CMD_POP) && !do_pop) begin
        status_r <= ST_POP_EMPTY;
      end else if ((command == CMD_PUSH) && is_full) begin
        status_r <= ST_PUSH_FULL;
      end else begin
        status_r <= ST_DONE;
      end
    end else if (ctrl.load) begin
      vtop <= vrd_data;
      mtop <= mrd_data;
    end
  end

  assign status     = status_r;
  assign is_empty   = (vcount == '0);
  assign fill_count = vcount;
  assign top_value  = (vcount == '0) ? '0 : vtop;
  assign min_value  = ((vcount == '0) || (mcount == '0)) ? '0 : mtop;

endmodule

`default_nettype wire

// File: rtl/mts_ctrl.sv
// mts_ctrl: request sequencing state machine of the min tracking stack
// depends on mts_pkg
`default_nettype none

module mts_ctrl
  import mts_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     in_valid,
  input  wire logic     out_stall,
  input  wire dp_stat_t stat,
  output logic          in_stall,
  output logic          out_valid,
  output dp_ctrl_t      ctrl
);

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next  = state;
    in_stall    = 1'b1;
    out_valid   = 1'b0;
    ctrl.accept = 1'b0;
    ctrl.load   = 1'b0;
    case (state)
      S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          ctrl.accept = 1'b1;
          state_next  = stat.needs_load ? S_LOAD : S_DONE;
        end
      end
      S_LOAD: begin
        ctrl.load  = 1'b1;
        state_next = S_DONE;
      end
      S_DONE: begin
        out_valid = 1'b1;
        if (!out_stall) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

// File: rtl/min_tracking_stack.sv
// min_tracking_stack: bounded lifo of signed 32-bit values with running minimum
// sequencing: a push, failed push or failed pop goes from IDLE to DONE; an effective pop
// passes through LOAD first, set by the registered ram read that refills the cached tops
// one request at a time: in_stall stays high until the result is taken by the receiver
// reset: synchronous rst empties both stores at once (counts to zero), no clearing pass
// depends on mts_pkg, mts_ctrl, mts_datapath, mts_ram
`default_nettype none

module min_tracking_stack
  import mts_pkg::*;
(
  input  wire logic                     clk,
  input  wire logic                     rst,
  // request channel
  input  wire logic                     in_valid,
  output logic                          in_stall,
  input  wire logic                     command,
  input  wire logic signed [DATA_W-1:0] value,
  // result channel
  output logic                          out_valid,
  input  wire logic                     out_stall,
  output logic [1:0]                    status,
  output logic                          is_empty,
  output logic [CNT_W-1:0]              fill_count,
  output logic signed [DATA_W-1:0]      top_value,
  output logic signed [DATA_W-1:0]      min_value
);

  // the controller only sequences; all stack state lives in the datapath
  dp_ctrl_t ctrl;
  dp_stat_t stat;

  mts_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .out_stall (out_stall),
    .stat      (stat),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .ctrl      (ctrl)
  );

  // tops of both stores are cached in registers so a push never reads ram;
  // a pop reads the entry below the old top and reloads the cache in the following LOAD state
  mts_datapath u_dp (
    .clk        (clk),
    .rst        (rst),
    .ctrl       (ctrl),
    .command    (command),
    .value      (value),
    .stat       (stat),
    .status     (status),
    .is_empty   (is_empty),
    .fill_count (fill_count),
    .top_value  (top_value),
    .min_value  (min_value)
  );

endmodule

`default_nettype wire

// File: rtl/mts_checker.sv
// mts_checker: port level assertions of the min tracking stack, bound to the top
// depends on mts_pkg
`default_nettype none

module mts_checker
  import mts_pkg::*;
(
  input wire logic                     clk,
  input wire logic                     rst,
  input wire logic                     in_valid,
  input wire logic                     in_stall,
  input wire logic                     command,
  input wire logic signed [DATA_W-1:0] value,
  input wire logic                     out_valid,
  input wire logic                     out_stall,
  input wire logic [1:0]               status,
  input wire logic                     is_empty,
  input wire logic [CNT_W-1:0]         fill_count,
  input wire logic signed [DATA_W-1:0] top_value,
  input wire logic signed [DATA_W-1:0] min_value
);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(fill_count) && $stable(min_value))
    else $error("stalled result changed");

  a_empty_flag: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (is_empty == (fill_count == '0)))
    else $error("empty flag disagrees with fill count");

  a_empty_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && is_empty |-> (top_value == '0) && (min_value == '0))
    else $error("empty stack reports nonzero top or minimum");

  a_full_drop: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status == ST_PUSH_FULL) |-> (fill_count == CNT_W'(STACK_DEPTH)))
    else $error("push dropped while not full");

  a_min_le_top: assert property (@(posedge clk) disable iff (rst)
    out_valid && !is_empty |-> (min_value <= top_value))
    else $error("minimum above top value");

endmodule

bind min_tracking_stack mts_checker u_mts_checker (.*);

`default_nettype wire

// File: tb/tb_min_tracking_stack.sv
// tb_min_tracking_stack: self-checking testbench for the min tracking stack
// predicts status, fill, top and minimum per request from its own copy of both stores
// depends on mts_pkg and min_tracking_stack
`default_nettype none

module tb_min_tracking_stack;
  import mts_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  // run limits
  localparam int  SETTLE_CYCLES  = 8;       // pause after the last result
  localparam int  HOLDOFF_CYCLES = 300;     // long receiver hold-off
  localparam real RUN_LIMIT_NS   = 2_000_000.0;

  // one request as queued for the driver
  typedef struct {
    logic                     cmd;
    logic signed [DATA_W-1:0] val;
  } stack_request_t;

  // the stack as the block should report it after one request
  typedef struct {
    status_t                  status;
    logic                     is_empty;
    logic [CNT_W-1:0]         fill;
    logic signed [DATA_W-1:0] top;
    logic signed [DATA_W-1:0] minv;
  } stack_snapshot_t;

  // clock and reset
  logic clk = 1'b0;
  logic rst = 1'b1;

  // request channel
  logic                     in_valid = 1'b0;
  logic                     in_stall;
  logic                     command  = CMD_PUSH;
  logic signed [DATA_W-1:0] value    = '0;

  // result channel
  logic                     out_valid;
  logic                     out_stall = 1'b0;
  logic [1:0]               status;
  logic                     is_empty;
  logic [CNT_W-1:0]         fill_count;
  logic signed [DATA_W-1:0] top_value;
  logic signed [DATA_W-1:0] min_value;

  // requests waiting for the driver and snapshots waiting for the monitor
  stack_request_t  pending_requests[$];
  stack_snapshot_t expected_snapshots[$];

  // predicted contents of the value store and the running-minimum store
  logic signed [DATA_W-1:0] pred_values[STACK_DEPTH];
  logic signed [DATA_W-1:0] pred_minimums[STACK_DEPTH];
  int                       pred_value_cnt   = 0;
  int                       pred_minimum_cnt = 0;

  // idling control, set per phase by the stimulus process
  int   send_idle_pct = 0;
  int   recv_idle_pct = 0;
  logic holdoff_armed = 1'b0;
  logic holdoff_taken = 1'b0;
  int   holdoff_left  = 0;

  int mismatch_count = 0;
  int gen_depth      = 0;   // fill level as the stimulus generator sees it

  min_tracking_stack uut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .command    (command),
    .value      (value),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .status     (status),
    .is_empty   (is_empty),
    .fill_count (fill_count),
    .top_value  (top_value),
    .min_value  (min_value)
  );

  // 4 ns clock
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // apply one accepted request to the predicted stack and queue the snapshot it yields
  task automatic predict_stack_request(input logic cmd, input logic signed [DATA_W-1:0] val);
    stack_snapshot_t snap;
    snap.status = ST_DONE;
    snap.top    = '0;
    snap.minv   = '0;
    if (cmd == CMD_PUSH) begin
      if (pred_value_cnt >= STACK_DEPTH) begin
        // full: value dropped, neither store moves
        snap.status = ST_PUSH_FULL;
      end else begin
        pred_values[pred_value_cnt] = val;
        pred_value_cnt++;
        // signed compare; duplicates of the minimum go on the minimum store too
        if (pred_minimum_cnt == 0 || val <= pred_minimums[pred_minimum_cnt-1]) begin
          if (pred_minimum_cnt < STACK_DEPTH) begin
            pred_minimums[pred_minimum_cnt] = val;
            pred_minimum_cnt++;
          end
        end
      end
    end else begin
      if (pred_value_cnt == 0) begin
        // pop on empty: ignored
        snap.status = ST_POP_EMPTY;
      end else begin
        if (pred_minimum_cnt > 0 &&
            pred_minimums[pred_minimum_cnt-1] == pred_values[pred_value_cnt-1]) begin
          pred_minimum_cnt--;
        end
        pred_value_cnt--;
      end
    end
    // top and minimum read as zero on an empty stack
    if (pred_value_cnt > 0) begin
      snap.top = pred_values[pred_value_cnt-1];
      if (pred_minimum_cnt > 0) begin
        snap.minv = pred_minimums[pred_minimum_cnt-1];
      end
    end
    snap.is_empty = (pred_value_cnt == 0);
    snap.fill     = pred_value_cnt[CNT_W-1:0];
    expected_snapshots.push_back(snap);
  endtask

  // driver: keeps a request steady until taken, then offers the next one or idles
  always @(posedge clk) begin
    logic taken;
    taken = in_valid && !in_stall;
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (taken) begin
        predict_stack_request(command, value);
        void'(pending_requests.pop_front());
      end
      if (in_valid && !taken) begin
        // stalled: payload and valid stay as they are
      end else if (pending_requests.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        in_valid <= 1'b1;
        command  <= pending_requests[0].cmd;
        value    <= pending_requests[0].val;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver stall: random per phase, with one long hold-off counted here
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else if (holdoff_left > 0) begin
      out_stall    <= 1'b1;
      holdoff_left <= holdoff_left - 1;
    end else if (holdoff_armed && !holdoff_taken) begin
      holdoff_taken <= 1'b1;
      holdoff_left  <= HOLDOFF_CYCLES;
      out_stall     <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  // field compare; only the first ten mismatches are printed
  task automatic check_field(input string field, input logic [DATA_W-1:0] exp_v,
                             input logic [DATA_W-1:0] act_v);
    if (exp_v !== act_v) begin
      mismatch_count++;
      if (mismatch_count <= 10) begin
        $display("mismatch at %0t: %s expected %h got %h", $realtime, field, exp_v, act_v);
      end
    end
  endtask

  // monitor: every taken result is checked against the oldest snapshot
  always @(posedge clk) begin
    stack_snapshot_t snap;
    if (!rst && out_valid && !out_stall) begin
      if (expected_snapshots.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10) begin
          $display("mismatch at %0t: result with no request outstanding", $realtime);
        end
      end else begin
        snap = expected_snapshots.pop_front();
        check_field("status",     DATA_W'(snap.status),   DATA_W'(status));
        check_field("is_empty",   DATA_W'(snap.is_empty), DATA_W'(is_empty));
        check_field("fill_count", DATA_W'(snap.fill),     DATA_W'(fill_count));
        check_field("top_value",  snap.top,               top_value);
        check_field("min_value",  snap.minv,              min_value);
      end
    end
  end

  // value mix: small range for duplicates and ties, extremes, full random
  function automatic logic signed [DATA_W-1:0] pick_value();
    int unsigned sel;
    sel = $urandom_range(9);
    if (sel < 4) begin
      pick_value = $urandom_range(16);
      pick_value = pick_value - 8;
    end else if (sel == 4) begin
      case ($urandom_range(3))
        0:       pick_value = 32'sh8000_0000;
        1:       pick_value = 32'sh7fff_ffff;
        2:       pick_value = '0;
        default: pick_value = -1;
      endcase
    end else begin
      pick_value = $urandom;
    end
  endfunction

  task automatic queue_request(input logic cmd, input logic signed [DATA_W-1:0] val);
    stack_request_t req;
    req.cmd = cmd;
    req.val = val;
    pending_requests.push_back(req);
    if (cmd == CMD_PUSH) begin
      if (gen_depth < STACK_DEPTH) gen_depth++;
    end else if (gen_depth > 0) begin
      gen_depth--;
    end
  endtask

  // random walk with a given share of pushes
  task automatic queue_walk(input int count, input int push_pct);
    for (int i = 0; i < count; i++) begin
      queue_request(($urandom_range(99) < push_pct) ? CMD_PUSH : CMD_POP, pick_value());
    end
  endtask

  // push until full, then a few pushes that must be dropped
  task automatic queue_fill(input int extra);
    while (gen_depth < STACK_DEPTH) queue_request(CMD_PUSH, pick_value());
    for (int i = 0; i < extra; i++) queue_request(CMD_PUSH, pick_value());
  endtask

  // pop until empty, then a few pops that must be ignored
  task automatic queue_drain(input int extra);
    while (gen_depth > 0) queue_request(CMD_POP, pick_value());
    for (int i = 0; i < extra; i++) queue_request(CMD_POP, pick_value());
  endtask

  // sender pause: wait for every request to be taken and every result to arrive
  task automatic wait_until_drained();
    while (pending_requests.size() != 0 || expected_snapshots.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // stimulus
  initial begin
    send_idle_pct = 38;
    recv_idle_pct = 87;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // directed: empty pop, duplicate minimums, signed extremes, back to empty
    queue_request(CMD_POP,  32'sd0);
    queue_request(CMD_POP,  -1);
    queue_request(CMD_PUSH, 32'sd5);
    queue_request(CMD_PUSH, 32'sd5);
    queue_request(CMD_PUSH, 32'sd7);
    queue_request(CMD_PUSH, 32'sd3);
    queue_request(CMD_PUSH, 32'sd3);
    queue_request(CMD_POP,  32'sd0);
    queue_request(CMD_POP,  32'sd0);
    queue_request(CMD_POP,  32'sd0);
    queue_request(CMD_PUSH, 32'sh7fff_ffff);
    queue_request(CMD_PUSH, 32'sh8000_0000);
    queue_request(CMD_PUSH, -1);
    queue_request(CMD_PUSH, 32'sd0);
    queue_request(CMD_PUSH, 32'sh8000_0000);
    queue_request(CMD_POP,  32'sh7fff_ffff);
    queue_request(CMD_POP,  32'sd0);
    queue_request(CMD_POP,  32'sd0);
    queue_request(CMD_POP,  32'sd0);
    queue_request(CMD_POP,  32'sd0);
    queue_request(CMD_POP,  32'sd0);
    queue_request(CMD_POP,  32'sd0);
    queue_request(CMD_POP,  32'sd0);
    wait_until_drained();

    // phase one: sender idles lightly, receiver heavily
    queue_walk(150, 60);
    queue_fill(3);
    queue_drain(3);
    wait_until_drained();

    // phase two: roles swapped
    send_idle_pct = 87;
    recv_idle_pct = 38;
    queue_walk(100, 52);
    queue_walk(100, 70);
    wait_until_drained();

    // phase three: no idling, long receiver hold-off while the sender keeps offering
    send_idle_pct = 0;
    recv_idle_pct = 0;
    holdoff_armed = 1'b1;
    queue_fill(5);
    queue_walk(60, 50);
    queue_drain(2);
    queue_walk(100, 55);
    wait_until_drained();

    if (mismatch_count == 0 && expected_snapshots.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // watchdog
  initial begin
    #(RUN_LIMIT_NS);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

`default_nettype wire
